### src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue unit: command and result
// beats, opcodes, status codes and sizing constants.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_NONE       = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] data_word;
  } deq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [63:0] front_word;
    logic [63:0] back_word;
  } deq_out_t;

endpackage

### src/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of raw words kept in a circular store with head
// and tail pointers and a fill count; reports status and both ends per beat.
// ----------------------------------------------------------------------------
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+----------------------------------------
//   command  | start, busy, cmd      | beat taken when start & !busy
//   result   | done, result          | one-cycle strobe, receiver cannot stall
//
// Every command runs through an accept, a read and a result cycle: the accept
// cycle moves the pointers and writes a pushed word, the read cycle reads the
// front and back slots, and the result cycle presents the result with done,
// since the slot store's reads are registered. busy stays high from the accept
// edge until the result cycle ends. Reset clears state, pointers, count and
// status; the slot store is not cleared, and a slot is read out only after it
// was written.
module double_ended_queue_unit
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  deq_in_t  cmd,
  output logic     done,
  output deq_out_t result
);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;

  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     head_next;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     tail_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [1:0]           stat;
  logic [1:0]           stat_next;

  logic                 accept;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [IDX_W-1:0]     back_idx;

  logic [WORD_BITS-1:0] slots [CAPACITY];
  logic [WORD_BITS-1:0] rd_front;
  logic [WORD_BITS-1:0] rd_back;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Work out pointer moves, the count and the store write for this beat.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    stat_next  = STAT_OK;
    wr_en      = 1'b0;
    wr_addr    = tail;
    wr_data    = cmd.data_word[WORD_BITS-1:0];
    case (cmd.opcode)
      OP_PUSH_FRONT: begin
        if (count == CNT_W'(CAPACITY)) begin
          stat_next = STAT_FULL;          // drop the word
        end else begin
          head_next  = wrap_dec(head);
          wr_en      = 1'b1;
          wr_addr    = wrap_dec(head);
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (count == CNT_W'(CAPACITY)) begin
          stat_next = STAT_FULL;
        end else begin
          tail_next  = wrap_inc(tail);
          wr_en      = 1'b1;
          wr_addr    = tail;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count == '0) begin
          stat_next = STAT_EMPTY;
        end else begin
          head_next  = wrap_inc(head);
          count_next = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count == '0) begin
          stat_next = STAT_EMPTY;
        end else begin
          tail_next  = wrap_dec(tail);
          count_next = count - 1'b1;
        end
      end
      default: begin
        // none and unused opcodes: hold everything, report success
      end
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_READ : S_IDLE;
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      stat  <= STAT_OK;
    end else begin
      state <= state_next;
      if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
        stat  <= stat_next;
      end
    end
  end

  // Slot store: one write port, two registered read ports. Reads use the
  // pointers as they stand, so in the read cycle they see the updated ends.
  assign back_idx = wrap_dec(tail);

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      slots[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_front <= slots[head];
    rd_back  <= slots[back_idx];
  end

  // Result beat: both ends read as zero on an empty queue.
  assign done               = (state == S_DONE);
  assign result.status      = stat;
  assign result.entry_count = 5'(count);
  assign result.is_empty    = (count == '0);
  assign result.front_word  = (count == '0) ? 64'd0 : 64'(rd_front);
  assign result.back_word   = (count == '0) ? 64'd0 : 64'(rd_back);

endmodule

### src/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue unit, bound into the unit module.
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input deq_out_t result
);

  a_result_two_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("no result two cycles after an accepted command beat");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && $past(busy))
    else $error("result strobe without a command in flight");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count <= 5'(CAPACITY)))
    else $error("entry count above capacity");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (result.front_word == 64'd0 &&
                                   result.back_word == 64'd0))
    else $error("front or back word nonzero on an empty queue");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);
